FILE: rtl/radio_reply_deframer_core_macros.svh
// Assertion macros shared by the deframer modules.
// ASSERT_IMPL checks cons in the same cycle as ante, ASSERT_NEXT in the cycle after it.
`ifndef RADIO_REPLY_DEFRAMER_CORE_MACROS_SVH
`define RADIO_REPLY_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RADD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define RADD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define RADD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RADD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/radd_pkg.sv
package radd_pkg;

  localparam int PAYLOAD_MAX  = 61;
  localparam int BUFFER_BYTES = 64;
  localparam int STORE_DEPTH  = 60;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int POS_W        = $clog2(BUFFER_BYTES + 2);
  localparam int LEN_W        = 6;

  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_TUSER_W  = 10;

  // Frame layout positions and length limits.
  localparam int POS_COUNT    = 1;
  localparam int POS_KIND     = 2;
  localparam int POS_DATA     = 3;
  localparam int MIN_XFER     = 4;
  localparam int FRAME_OVHD   = 3;
  localparam int STATUS_MIN   = 3;

  typedef struct packed {
    logic take_byte;   // input transaction
    logic take_last;   // input transaction carrying the end mark
    logic fetch;       // read store at current result index
    logic advance;     // result taken, more to follow
    logic done;        // final result taken
  } radd_cmd_t;

  typedef struct packed {
    logic last_result; // current result is the final one of the transfer
  } radd_stat_t;

  typedef struct packed {
    logic                 frame_ok;
    logic [7:0]           reply_kind;
    logic [LEN_W-1:0]     data_length;
    logic [LEN_W-1:0]     data_index;
    logic [7:0]           data_byte;
    logic                 status_reply;
    logic                 last;
  } radd_result_t;

endpackage

FILE: rtl/radd_ctrl.sv
`include "radio_reply_deframer_core_macros.svh"

module radd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output radd_pkg::radd_cmd_t cmd,
  input  radd_pkg::radd_stat_t stat
);
  import radd_pkg::*;

  typedef enum logic [2:0] {
    S_RECV  = 3'b001,
    S_FETCH = 3'b010,
    S_SEND  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   in_hs, out_hs;

  assign in_tready  = (state_r == S_RECV);
  assign out_tvalid = (state_r == S_SEND);
  assign in_hs      = in_tvalid && in_tready;
  assign out_hs     = out_tvalid && out_tready;

  assign cmd.take_byte = in_hs;
  assign cmd.take_last = in_hs && in_tlast;
  assign cmd.fetch     = (state_r == S_FETCH);
  assign cmd.advance   = out_hs && !stat.last_result;
  assign cmd.done      = out_hs && stat.last_result;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RECV:  if (in_hs && in_tlast) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_SEND;
      S_SEND: begin
        if (out_hs) state_nxt = stat.last_result ? S_RECV : S_FETCH;
      end
      default: state_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RADD_ASSERT_IMPL(a_ready_valid_excl, clk, rst_n, 1'b1, !(in_tready && out_tvalid))
  `RADD_ASSERT_NEXT(a_eot_starts_emit, clk, rst_n, in_tvalid && in_tready && in_tlast,
                    !in_tready && !out_tvalid)
  `RADD_ASSERT_NEXT(a_last_returns, clk, rst_n, out_tvalid && out_tready && stat.last_result,
                    in_tready)
endmodule

FILE: rtl/radd_dp.sv
`include "radio_reply_deframer_core_macros.svh"

module radd_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             rx_byte,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  radd_pkg::radd_cmd_t    cmd,
  output radd_pkg::radd_stat_t   stat,
  output radd_pkg::radd_result_t res
);
  import radd_pkg::*;

  // Frame state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [7:0]          count_r, count_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          kind_r, kind_nxt;
  logic [7:0]          chk_r, chk_nxt;
  logic [7:0]          status_kind_r;

  // Verdict held while results drain
  logic                v_ok_r;
  logic                v_data_r;
  logic [7:0]          v_kind_r;
  logic [LEN_W-1:0]    v_len_r;
  logic                v_stat_r;
  logic [LEN_W-1:0]    idx_r;
  logic [7:0]          rd_data_r;

  logic [7:0]          store_mem_r [STORE_DEPTH];
  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr;
  logic [POS_W-1:0]    slot;

  logic                in_buf, in_sum, is_chk;
  logic [8:0]          cnt_lim, pos9;
  logic [POS_W-1:0]    pos_inc;
  logic                ok;
  logic [LEN_W-1:0]    len;

  assign in_buf  = pos_r < POS_W'(BUFFER_BYTES);
  assign pos9    = 9'(pos_r);
  assign cnt_lim = {1'b0, count_r} + 9'(POS_KIND);
  assign in_sum  = in_buf && (pos_r >= POS_W'(POS_KIND)) && (pos9 < cnt_lim);
  assign is_chk  = in_buf && (pos_r >= POS_W'(POS_KIND)) && (pos9 == cnt_lim);
  assign slot    = pos_r - POS_W'(POS_DATA);
  assign wr_en   = cmd.take_byte && in_sum && (pos_r >= POS_W'(POS_DATA)) &&
                   (slot < POS_W'(STORE_DEPTH));
  assign wr_addr = slot[STORE_AW-1:0];
  assign pos_inc = (pos_r < POS_W'(BUFFER_BYTES + 1)) ? pos_r + POS_W'(1) : pos_r;

  always_comb begin
    count_nxt = count_r;
    kind_nxt  = kind_r;
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    if (in_buf && pos_r == POS_W'(POS_COUNT)) count_nxt = rx_byte;
    if (in_buf && pos_r == POS_W'(POS_KIND))  kind_nxt  = rx_byte;
    if (in_sum) sum_nxt = sum_r + rx_byte;
    if (is_chk) chk_nxt = rx_byte;
  end

  // Verdict from the state as it stands after the final byte
  assign ok = (pos_inc >= POS_W'(MIN_XFER)) && (pos_inc <= POS_W'(BUFFER_BYTES)) &&
              (count_nxt != 8'd0) && (count_nxt <= 8'(PAYLOAD_MAX)) &&
              ({1'b0, count_nxt} + 9'(FRAME_OVHD) <= 9'(pos_inc)) &&
              (sum_nxt == chk_nxt);
  assign len = LEN_W'(count_nxt - 8'd1);

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.take_byte) pos_nxt = cmd.take_last ? '0 : pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      kind_r        <= '0;
      chk_r         <= '0;
      idx_r         <= '0;
      status_kind_r <= '0;
    end else begin
      if (cfg_wr_en) status_kind_r <= cfg_wr_data;
      pos_r <= pos_nxt;
      if (cmd.take_last) begin
        count_r <= '0;
        sum_r   <= '0;
        kind_r  <= '0;
        chk_r   <= '0;
        idx_r   <= '0;
      end else if (cmd.take_byte) begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        kind_r  <= kind_nxt;
        chk_r   <= chk_nxt;
      end
      if (cmd.advance) idx_r <= idx_r + LEN_W'(1);
      if (cmd.done)    idx_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_last) begin
      v_ok_r   <= ok;
      v_data_r <= ok && (len != '0);
      v_kind_r <= ok ? kind_nxt : 8'd0;
      v_len_r  <= ok ? len : '0;
      v_stat_r <= ok && (kind_nxt == status_kind_r) && (len >= LEN_W'(STATUS_MIN));
    end
  end

  // Store: one write port while receiving, one registered read while draining
  always_ff @(posedge clk) begin
    if (wr_en) store_mem_r[wr_addr] <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) rd_data_r <= store_mem_r[idx_r[STORE_AW-1:0]];
  end

  assign stat.last_result = !v_data_r || ({1'b0, idx_r} + 7'd1 == {1'b0, v_len_r});

  assign res.frame_ok     = v_ok_r;
  assign res.reply_kind   = v_kind_r;
  assign res.data_length  = v_len_r;
  assign res.data_index   = idx_r;
  assign res.data_byte    = v_data_r ? rd_data_r : 8'd0;
  assign res.status_reply = v_stat_r;
  assign res.last         = stat.last_result;

  `RADD_ASSERT_IMPL(a_pos_bounded, clk, rst_n, 1'b1, pos_r <= POS_W'(BUFFER_BYTES + 1))
  `RADD_ASSERT_IMPL(a_fetch_in_range, clk, rst_n, cmd.fetch && v_data_r,
                    idx_r < v_len_r)
  `RADD_ASSERT_NEXT(a_eot_clears, clk, rst_n, cmd.take_last,
                    pos_r == '0 && sum_r == 8'd0 && idx_r == '0)
endmodule

FILE: rtl/radio_reply_deframer_core.sv
// Radio reply deframer. Bytes of one received transfer enter on the in_ stream, one
// per transaction, with in_tlast on the final byte. Byte 0 is skipped, byte 1 is the
// count, bytes 2..count+1 are summed modulo 256 and the byte after them is the
// checksum; byte 2 is the reply kind and the following bytes are data, buffered in a
// 60-entry store. On the final byte the transfer is checked (length 4..64, count
// nonzero, at most 61 and fitting the transfer, sum equal to checksum). A failed
// transfer yields one result with frame_ok low; a good one yields one result per data
// byte, or one empty result when there is no data. status_reply flags replies whose
// kind equals the status_kind register (cfg_wr_en / cfg_wr_data) and carry three or
// more data bytes. Bytes are taken while in_tready is high; after the final byte
// in_tready stays low while results drain. Each result is fetched by a registered
// read of the store's single read port (FETCH state) and then presented (SEND
// state) until out_tready takes it. in_tready rises again once the final result of
// the transfer has been taken.
module radio_reply_deframer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [radd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] rx_byte
  input  logic                              in_tlast,   // end_of_transfer
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [radd_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [5:0] data_length,
                                                        // [11:6] data_index,
                                                        // [19:12] data_byte, [23:20] zero
  output logic [radd_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] frame_ok, [8:1] reply_kind,
                                                        // [9] status_reply
  output logic                              out_tlast,  // last
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [7:0]                        cfg_wr_data // status_kind
);
  import radd_pkg::*;

  radd_cmd_t    cmd;
  radd_stat_t   stat;
  radd_result_t res;

  // Sequence byte intake and result drain
  radd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Hold frame state, checks, data store and the result fields
  radd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte     (in_tdata[7:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .res         (res)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {4'd0, res.data_byte, res.data_index, res.data_length};
  assign out_tuser = {res.status_reply, res.reply_kind, res.frame_ok};
  assign out_tlast = res.last;
endmodule
